// File: sv/page_frame_cache_round_robin_unit_macros.svh
// Assertion macros for the page frame cache checker
`ifndef PAGE_FRAME_CACHE_ROUND_ROBIN_UNIT_MACROS_SVH
`define PAGE_FRAME_CACHE_ROUND_ROBIN_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define PFC_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low
`define PFC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/pfc_pkg.sv
// Shared constants, types and codes for the page frame cache
package pfc_pkg;

    // Geometry
    localparam int FRAMES   = 16;
    localparam int IDX_W    = $clog2(FRAMES);
    localparam int FCNT_W   = $clog2(FRAMES + 1);
    localparam int PAGE_W   = 31;
    localparam int FRAME_W  = 4;
    localparam int COUNT_W  = 5;
    localparam int STAT_W   = 32;
    localparam int KIND_W   = 3;
    localparam int OP_W     = 2;

    // Operation codes
    localparam logic [OP_W-1:0] OP_FETCH = 2'd0;
    localparam logic [OP_W-1:0] OP_MARK  = 2'd1;
    localparam logic [OP_W-1:0] OP_FLUSH = 2'd2;

    // Result kinds
    localparam logic [KIND_W-1:0] K_HIT    = 3'd0;
    localparam logic [KIND_W-1:0] K_LOAD   = 3'd1;
    localparam logic [KIND_W-1:0] K_WB     = 3'd2;
    localparam logic [KIND_W-1:0] K_EVLOAD = 3'd3;
    localparam logic [KIND_W-1:0] K_REJECT = 3'd4;
    localparam logic [KIND_W-1:0] K_FWRITE = 3'd5;
    localparam logic [KIND_W-1:0] K_FDONE  = 3'd6;
    localparam logic [KIND_W-1:0] K_MARK   = 3'd7;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_FSCAN,
        S_EVICT,
        S_WBACK,
        S_EVLOAD,
        S_SINGLE,
        S_MARK,
        S_FCNT,
        S_FWALK,
        S_FDONE
    } t_state;

    // Write port of the frame table
    typedef struct packed {
        logic              page_en;
        logic              valid_en;
        logic              dirty_en;
        logic [IDX_W-1:0]  addr;
        logic [PAGE_W-1:0] page;
        logic              valid;
        logic              dirty;
    } t_tbl_wr;

    // Read port of the frame table
    typedef struct packed {
        logic [PAGE_W-1:0] page;
        logic              valid;
        logic              dirty;
    } t_tbl_rd;

    // One result transaction as held in the output register
    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [FRAME_W-1:0] frame;
        logic [PAGE_W-1:0]  page;
        logic [COUNT_W-1:0] count;
        logic [STAT_W-1:0]  hits;
        logic [STAT_W-1:0]  misses;
        logic [STAT_W-1:0]  evictions;
        logic [STAT_W-1:0]  writebacks;
        logic               last;
    } t_res;

endpackage

// File: sv/pfc_ifs.sv
// Valid/ready channel interfaces for request and result transactions
interface pfc_in_if import pfc_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          operation;
    logic signed [STAT_W-1:0] page_id;
    logic [FRAME_W-1:0]       frame_index;

    modport source (output valid, operation, page_id, frame_index, input ready);
    modport sink   (input valid, operation, page_id, frame_index, output ready);
endinterface

interface pfc_out_if import pfc_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  kind;
    logic [FRAME_W-1:0] frame;
    logic [PAGE_W-1:0]  disk_page;
    logic [COUNT_W-1:0] flushed_count;
    logic [STAT_W-1:0]  hit_count;
    logic [STAT_W-1:0]  miss_count;
    logic [STAT_W-1:0]  eviction_count;
    logic [STAT_W-1:0]  writeback_count;
    logic               last;

    modport source (output valid, kind, frame, disk_page, flushed_count, hit_count,
                    miss_count, eviction_count, writeback_count, last, input ready);
    modport sink   (input valid, kind, frame, disk_page, flushed_count, hit_count,
                    miss_count, eviction_count, writeback_count, last, output ready);
endinterface

// File: sv/pfc_table.sv
// Frame table: page numbers plus valid and dirty marks, one read and one write port
module pfc_table import pfc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [IDX_W-1:0] i_rd_addr,
    input  t_tbl_wr          i_wr,
    output t_tbl_rd          o_rd
);

    logic [PAGE_W-1:0] r_page [FRAMES];
    logic [FRAMES-1:0] r_valid;
    logic [FRAMES-1:0] r_dirty;

    // Write page numbers; no reset, only read behind a valid mark
    always_ff @(posedge i_clk) begin
        if (i_wr.page_en) begin
            r_page[i_wr.addr] <= i_wr.page;
        end
    end

    // Update valid and dirty marks
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_dirty <= '0;
        end else begin
            if (i_wr.valid_en) begin
                r_valid[i_wr.addr] <= i_wr.valid;
            end
            if (i_wr.dirty_en) begin
                r_dirty[i_wr.addr] <= i_wr.dirty;
            end
        end
    end

    // Read the addressed frame
    assign o_rd.page  = r_page[i_rd_addr];
    assign o_rd.valid = r_valid[i_rd_addr];
    assign o_rd.dirty = r_dirty[i_rd_addr];

endmodule

// File: sv/page_frame_cache_round_robin_unit.sv
// Page frame cache with round-robin replacement: one frame examined per cycle,
// held while a flush writeback waits on the output. A fetch scans to a hit, else
// loads an empty frame or evicts the victim, writing it back first if dirty.
// One request at a time; the rate is set by the single read port of the frame
// table that the sequencer walks. Output stalls add cycles.
// Synchronous active-low reset empties all frames and clears pointer and counters.
module page_frame_cache_round_robin_unit import pfc_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    pfc_in_if.sink    i_in,
    pfc_out_if.source o_out
);

    t_state r_state, n_state;

    // Request and scan registers
    logic [PAGE_W-1:0]  r_page,  n_page;
    logic [FRAME_W-1:0] r_fidx,  n_fidx;
    logic [IDX_W-1:0]   r_idx,   n_idx;
    logic               r_efound, n_efound;
    logic [IDX_W-1:0]   r_eidx,  n_eidx;
    logic [IDX_W-1:0]   r_vic,   n_vic;
    logic [IDX_W-1:0]   r_ptr,   n_ptr;
    logic [FCNT_W-1:0]  r_cnt,   n_cnt;

    // Pending single result
    logic [KIND_W-1:0]  r_pkind, n_pkind;
    logic [IDX_W-1:0]   r_pframe, n_pframe;
    logic [PAGE_W-1:0]  r_ppage, n_ppage;

    // Statistics
    logic [STAT_W-1:0]  r_hits, n_hits;
    logic [STAT_W-1:0]  r_misses, n_misses;
    logic [STAT_W-1:0]  r_evs, n_evs;
    logic [STAT_W-1:0]  r_wbs, n_wbs;

    // Output register
    logic               r_out_valid, n_out_valid;
    t_res               r_out, n_out;

    // Table port and helper signals
    logic [IDX_W-1:0]   rd_addr;
    t_tbl_wr            tbl_wr;
    t_tbl_rd            tbl_rd;
    logic               accept;
    logic               slot_free;
    logic               last_idx;
    logic               match;
    logic               empty_now;
    logic [IDX_W-1:0]   empty_idx;
    logic               vd;
    logic               mark_ok;
    logic               emit;
    logic [KIND_W-1:0]  e_kind;
    logic [IDX_W-1:0]   e_frame;
    logic [PAGE_W-1:0]  e_page;
    logic [COUNT_W-1:0] e_count;
    logic               e_last;

    pfc_table u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (rd_addr),
        .i_wr      (tbl_wr),
        .o_rd      (tbl_rd)
    );

    assign i_in.ready = (r_state == S_IDLE);
    assign accept     = i_in.valid && i_in.ready;
    assign slot_free  = !r_out_valid || o_out.ready;
    assign last_idx   = (r_idx == IDX_W'(FRAMES - 1));
    assign match      = tbl_rd.valid && (tbl_rd.page == r_page);
    assign empty_now  = r_efound || !tbl_rd.valid;
    assign empty_idx  = r_efound ? r_eidx : r_idx;
    assign vd         = tbl_rd.valid && tbl_rd.dirty;
    assign mark_ok    = (int'(r_fidx) < FRAMES) && tbl_rd.valid;

    // Select the frame under examination
    always_comb begin
        case (r_state)
            S_EVICT, S_WBACK: rd_addr = r_vic;
            S_MARK:           rd_addr = IDX_W'(r_fidx);
            default:          rd_addr = r_idx;
        endcase
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_in.operation)
                        OP_FETCH: n_state = i_in.page_id[STAT_W-1] ? S_SINGLE : S_FSCAN;
                        OP_MARK:  n_state = S_MARK;
                        OP_FLUSH: n_state = S_FCNT;
                        default:  n_state = S_SINGLE;
                    endcase
                end
            end
            S_FSCAN: begin
                if (match) begin
                    n_state = S_SINGLE;
                end else if (last_idx) begin
                    n_state = empty_now ? S_SINGLE : S_EVICT;
                end
            end
            S_EVICT:  n_state = tbl_rd.dirty ? S_WBACK : S_EVLOAD;
            S_WBACK:  if (slot_free) n_state = S_EVLOAD;
            S_EVLOAD: if (slot_free) n_state = S_IDLE;
            S_SINGLE: if (slot_free) n_state = S_IDLE;
            S_MARK:   if (slot_free) n_state = S_IDLE;
            S_FCNT:   if (last_idx) n_state = S_FWALK;
            S_FWALK: begin
                if ((!vd || slot_free) && last_idx) begin
                    n_state = S_FDONE;
                end
            end
            S_FDONE:  if (slot_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // Datapath, table writes and result generation
    always_comb begin
        n_page   = r_page;
        n_fidx   = r_fidx;
        n_idx    = r_idx;
        n_efound = r_efound;
        n_eidx   = r_eidx;
        n_vic    = r_vic;
        n_ptr    = r_ptr;
        n_cnt    = r_cnt;
        n_pkind  = r_pkind;
        n_pframe = r_pframe;
        n_ppage  = r_ppage;
        n_hits   = r_hits;
        n_misses = r_misses;
        n_evs    = r_evs;
        n_wbs    = r_wbs;
        tbl_wr   = '0;
        emit     = 1'b0;
        e_kind   = K_REJECT;
        e_frame  = '0;
        e_page   = '0;
        e_count  = '0;
        e_last   = 1'b1;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_page   = i_in.page_id[PAGE_W-1:0];
                    n_fidx   = i_in.frame_index;
                    n_idx    = '0;
                    n_efound = 1'b0;
                    n_cnt    = '0;
                    n_pkind  = K_REJECT;
                    n_pframe = '0;
                    n_ppage  = '0;
                end
            end
            S_FSCAN: begin
                // Hit ends the scan; otherwise remember the lowest empty frame
                if (match) begin
                    n_hits   = r_hits + 1'b1;
                    n_pkind  = K_HIT;
                    n_pframe = r_idx;
                    n_ppage  = r_page;
                end else if (last_idx) begin
                    if (empty_now) begin
                        tbl_wr.page_en  = 1'b1;
                        tbl_wr.valid_en = 1'b1;
                        tbl_wr.dirty_en = 1'b1;
                        tbl_wr.addr     = empty_idx;
                        tbl_wr.page     = r_page;
                        tbl_wr.valid    = 1'b1;
                        tbl_wr.dirty    = 1'b0;
                        n_misses        = r_misses + 1'b1;
                        n_pkind         = K_LOAD;
                        n_pframe        = empty_idx;
                        n_ppage         = r_page;
                    end else begin
                        n_vic = r_ptr;
                    end
                end else begin
                    if (!tbl_rd.valid && !r_efound) begin
                        n_efound = 1'b1;
                        n_eidx   = r_idx;
                    end
                    n_idx = r_idx + 1'b1;
                end
            end
            S_EVICT: begin
                // Settle counters and advance the pointer before any result goes out
                n_evs    = r_evs + 1'b1;
                n_misses = r_misses + 1'b1;
                if (tbl_rd.dirty) begin
                    n_wbs = r_wbs + 1'b1;
                end
                n_ptr = (r_vic == IDX_W'(FRAMES - 1)) ? '0 : r_vic + 1'b1;
            end
            S_WBACK: begin
                if (slot_free) begin
                    emit    = 1'b1;
                    e_kind  = K_WB;
                    e_frame = r_vic;
                    e_page  = tbl_rd.page;
                    e_last  = 1'b0;
                end
            end
            S_EVLOAD: begin
                if (slot_free) begin
                    emit            = 1'b1;
                    e_kind          = K_EVLOAD;
                    e_frame         = r_vic;
                    e_page          = r_page;
                    tbl_wr.page_en  = 1'b1;
                    tbl_wr.valid_en = 1'b1;
                    tbl_wr.dirty_en = 1'b1;
                    tbl_wr.addr     = r_vic;
                    tbl_wr.page     = r_page;
                    tbl_wr.valid    = 1'b1;
                    tbl_wr.dirty    = 1'b0;
                end
            end
            S_SINGLE: begin
                if (slot_free) begin
                    emit    = 1'b1;
                    e_kind  = r_pkind;
                    e_frame = r_pframe;
                    e_page  = r_ppage;
                end
            end
            S_MARK: begin
                if (slot_free) begin
                    emit    = 1'b1;
                    e_kind  = K_MARK;
                    e_frame = IDX_W'(r_fidx);
                    e_page  = mark_ok ? tbl_rd.page : '0;
                    if (mark_ok) begin
                        tbl_wr.dirty_en = 1'b1;
                        tbl_wr.addr     = IDX_W'(r_fidx);
                        tbl_wr.dirty    = 1'b1;
                    end
                end
            end
            S_FCNT: begin
                // Count dirty frames first so every flush result carries the final total
                n_cnt = r_cnt + FCNT_W'(vd);
                if (last_idx) begin
                    n_wbs = r_wbs + STAT_W'(n_cnt);
                    n_idx = '0;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_FWALK: begin
                if (!vd || slot_free) begin
                    if (vd) begin
                        emit            = 1'b1;
                        e_kind          = K_FWRITE;
                        e_frame         = r_idx;
                        e_page          = tbl_rd.page;
                        e_last          = 1'b0;
                        tbl_wr.dirty_en = 1'b1;
                        tbl_wr.addr     = r_idx;
                        tbl_wr.dirty    = 1'b0;
                    end
                    if (!last_idx) begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            S_FDONE: begin
                if (slot_free) begin
                    emit    = 1'b1;
                    e_kind  = K_FDONE;
                    e_count = COUNT_W'(r_cnt);
                end
            end
            default: begin
                emit = 1'b0;
            end
        endcase

        // Load or drain the output register
        n_out_valid = r_out_valid && !o_out.ready;
        n_out       = r_out;
        if (emit) begin
            n_out_valid      = 1'b1;
            n_out.kind       = e_kind;
            n_out.frame      = FRAME_W'(e_frame);
            n_out.page       = e_page;
            n_out.count      = e_count;
            n_out.hits       = r_hits;
            n_out.misses     = r_misses;
            n_out.evictions  = r_evs;
            n_out.writebacks = r_wbs;
            n_out.last       = e_last;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ptr       <= '0;
            r_hits      <= '0;
            r_misses    <= '0;
            r_evs       <= '0;
            r_wbs       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ptr       <= n_ptr;
            r_hits      <= n_hits;
            r_misses    <= n_misses;
            r_evs       <= n_evs;
            r_wbs       <= n_wbs;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_page   <= n_page;
        r_fidx   <= n_fidx;
        r_idx    <= n_idx;
        r_efound <= n_efound;
        r_eidx   <= n_eidx;
        r_vic    <= n_vic;
        r_cnt    <= n_cnt;
        r_pkind  <= n_pkind;
        r_pframe <= n_pframe;
        r_ppage  <= n_ppage;
        r_out    <= n_out;
    end

    // Drive the result channel
    assign o_out.valid           = r_out_valid;
    assign o_out.kind            = r_out.kind;
    assign o_out.frame           = r_out.frame;
    assign o_out.disk_page       = r_out.page;
    assign o_out.flushed_count   = r_out.count;
    assign o_out.hit_count       = r_out.hits;
    assign o_out.miss_count      = r_out.misses;
    assign o_out.eviction_count  = r_out.evictions;
    assign o_out.writeback_count = r_out.writebacks;
    assign o_out.last            = r_out.last;

endmodule

// File: sv/pfc_checker.sv
// Port-level checker for the page frame cache, bound to the top level
`include "page_frame_cache_round_robin_unit_macros.svh"

module pfc_checker import pfc_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic [KIND_W-1:0]  i_out_kind,
    input logic [PAGE_W-1:0]  i_out_disk_page,
    input logic [COUNT_W-1:0] i_out_flushed_count,
    input logic               i_out_last
);

    // A stalled result transaction holds
    `PFC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_kind) && $stable(i_out_disk_page) && $stable(i_out_last), "stalled result changed")

    // One request at a time: ready drops after a request transaction
    `PFC_ASSERT_NEXT(a_busy, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready, "request taken while busy")

    // Flush done closes its request
    `PFC_ASSERT_SAME(a_fdone_last, i_clk, i_rst_n, i_out_valid && i_out_kind == K_FDONE, i_out_last, "flush done not last")

    // Flush count only on flush done
    `PFC_ASSERT_SAME(a_count_zero, i_clk, i_rst_n, i_out_valid && i_out_kind != K_FDONE, i_out_flushed_count == '0, "stray flush count")

    // Writebacks are never the final result
    `PFC_ASSERT_SAME(a_wb_not_last, i_clk, i_rst_n, i_out_valid && (i_out_kind == K_WB || i_out_kind == K_FWRITE), !i_out_last, "writeback marked last")

endmodule

bind page_frame_cache_round_robin_unit pfc_checker u_pfc_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .i_in_valid          (i_in.valid),
    .i_in_ready          (i_in.ready),
    .i_out_valid         (o_out.valid),
    .i_out_ready         (o_out.ready),
    .i_out_kind          (o_out.kind),
    .i_out_disk_page     (o_out.disk_page),
    .i_out_flushed_count (o_out.flushed_count),
    .i_out_last          (o_out.last)
);

// File: tb/page_frame_cache_round_robin_unit_test.sv
// Self-checking testbench for the round-robin page frame cache: directed table, then random traffic
module page_frame_cache_round_robin_unit_test;
    import pfc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Operation code that the block treats as a reject
    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

    localparam int POOL_SIZE        = 24;
    localparam int RANDOM_PER_PHASE = 46;
    localparam int PHASES           = 4;
    localparam int MAX_GAP          = 17;
    localparam int LONG_HOLD        = 300;
    localparam int STALL_LIMIT      = 2000;
    localparam int DRAIN_CYCLES     = 4 * FRAMES;
    localparam int REPORT_LIMIT     = 10;

    // One request transaction, with the result typed in where it is obvious
    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [STAT_W-1:0]  pid;
        logic [FRAME_W-1:0] idx;
        logic               typed;
        logic [KIND_W-1:0]  kind;
        logic [FRAME_W-1:0] frame;
        logic [PAGE_W-1:0]  page;
        logic [COUNT_W-1:0] count;
    } t_row;

    localparam int DIRECTED_ROWS = 27;

    // Directed stimulus: empty-cache corners, negative pages, fill, evictions and flush
    localparam t_row DIRECTED [DIRECTED_ROWS] = '{
        '{OP_FLUSH, 32'h0000_0000, 4'd0,  1'b1, K_FDONE,  4'd0, 31'd0,          5'd0},
        '{OP_MARK,  32'h0000_0000, 4'd15, 1'b1, K_MARK,   4'd15, 31'd0,         5'd0},
        '{OP_FETCH, 32'h8000_0000, 4'd0,  1'b1, K_REJECT, 4'd0, 31'd0,          5'd0},
        '{OP_FETCH, 32'hFFFF_FFFF, 4'd15, 1'b1, K_REJECT, 4'd0, 31'd0,          5'd0},
        '{OP_SPARE, 32'h0000_0005, 4'd0,  1'b1, K_REJECT, 4'd0, 31'd0,          5'd0},
        '{OP_FETCH, 32'h0000_0000, 4'd0,  1'b1, K_LOAD,   4'd0, 31'd0,          5'd0},
        '{OP_FETCH, 32'h7FFF_FFFF, 4'd0,  1'b1, K_LOAD,   4'd1, 31'h7FFF_FFFF,  5'd0},
        '{OP_FETCH, 32'h0000_0000, 4'd0,  1'b1, K_HIT,    4'd0, 31'd0,          5'd0},
        '{OP_MARK,  32'h0000_0000, 4'd1,  1'b1, K_MARK,   4'd1, 31'h7FFF_FFFF,  5'd0},
        '{OP_FETCH, 32'd2,         4'd0,  1'b0, K_HIT,    4'd0, 31'd0,          5'd0},
        '{OP_FETCH, 32'd3,         4'd0,  1'b0, K_HIT,    4'd0, 31'd0,          5'd0},
        '{OP_FETCH, 32'd4,         4'd0,  1'b0, K_HIT,    4'd0, 31'd0,          5'd0},
        '{OP_FETCH, 32'd5,         4'd0,  1'b0, K_HIT,    4'd0, 31'd0,          5'd0},
        '{OP_FETCH, 32'd6,         4'd0,  1'b0, K_HIT,    4'd0, 31'd0,          5'd0},
        '{OP_FETCH, 32'd7,         4'd0,  1'b0, K_HIT,    4'd0, 31'd0,          5'd0},
        '{OP_FETCH, 32'd8,         4'd0,  1'b0, K_HIT,    4'd0, 31'd0,          5'd0},
        '{OP_FETCH, 32'd9,         4'd0,  1'b0, K_HIT,    4'd0, 31'd0,          5'd0},
        '{OP_FETCH, 32'd10,        4'd0,  1'b0, K_HIT,    4'd0, 31'd0,          5'd0},
        '{OP_FETCH, 32'd11,        4'd0,  1'b0, K_HIT,    4'd0, 31'd0,          5'd0},
        '{OP_FETCH, 32'd12,        4'd0,  1'b0, K_HIT,    4'd0, 31'd0,          5'd0},
        '{OP_FETCH, 32'd13,        4'd0,  1'b0, K_HIT,    4'd0, 31'd0,          5'd0},
        '{OP_FETCH, 32'd14,        4'd0,  1'b0, K_HIT,    4'd0, 31'd0,          5'd0},
        '{OP_FETCH, 32'd15,        4'd0,  1'b0, K_HIT,    4'd0, 31'd0,          5'd0},
        '{OP_FETCH, 32'd100,       4'd0,  1'b0, K_HIT,    4'd0, 31'd0,          5'd0},
        '{OP_FETCH, 32'd101,       4'd0,  1'b0, K_HIT,    4'd0, 31'd0,          5'd0},
        '{OP_MARK,  32'h0000_0000, 4'd3,  1'b0, K_HIT,    4'd0, 31'd0,          5'd0},
        '{OP_FLUSH, 32'h0000_0000, 4'd0,  1'b0, K_HIT,    4'd0, 31'd0,          5'd0}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    pfc_in_if  req_if ();
    pfc_out_if res_if ();

    page_frame_cache_round_robin_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_if),
        .o_out   (res_if)
    );

    // Shadow copy of the frame table and its statistics
    logic [PAGE_W-1:0]  cached_page  [FRAMES];
    logic               cached_valid [FRAMES] = '{default: 1'b0};
    logic               cached_dirty [FRAMES] = '{default: 1'b0};
    logic [IDX_W-1:0]   next_victim  = '0;
    logic [STAT_W-1:0]  hits_seen    = '0;
    logic [STAT_W-1:0]  misses_seen  = '0;
    logic [STAT_W-1:0]  evicts_seen  = '0;
    logic [STAT_W-1:0]  wbacks_seen  = '0;

    t_res               step_results [$];
    t_res               due_results  [$];
    t_row               offered_rows [$];
    logic [PAGE_W-1:0]  page_pool    [POOL_SIZE];

    logic               quiet           = 1'b0;
    int                 hold_off_cycles = 0;
    int                 mismatches      = 0;
    int                 stalled_cycles  = 0;

    // Clock: 10 ns period
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Append one result of the current request
    function automatic void add_result(input logic [KIND_W-1:0] kind,
                                       input logic [FRAME_W-1:0] frame,
                                       input logic [PAGE_W-1:0] page,
                                       input logic [COUNT_W-1:0] count);
        t_res r;
        r       = '0;
        r.kind  = kind;
        r.frame = frame;
        r.page  = page;
        r.count = count;
        step_results.push_back(r);
    endfunction

    // Apply one request to the shadow table and collect the results it causes
    function automatic void advance_cache(input logic [OP_W-1:0] op,
                                          input logic [STAT_W-1:0] pid,
                                          input logic [FRAME_W-1:0] idx);
        int                 hit_at;
        int                 free_at;
        logic [IDX_W-1:0]   v;
        logic [PAGE_W-1:0]  pg;
        logic [COUNT_W-1:0] flushed;
        hit_at  = -1;
        free_at = -1;
        flushed = '0;
        pg      = '0;
        step_results.delete();
        if (op == OP_FETCH) begin
            if (pid[STAT_W-1]) begin
                add_result(K_REJECT, '0, '0, '0);
            end else begin
                for (int i = 0; i < FRAMES; i++) begin
                    if (hit_at < 0 && cached_valid[i] && cached_page[i] == pid[PAGE_W-1:0])
                        hit_at = i;
                    if (free_at < 0 && !cached_valid[i])
                        free_at = i;
                end
                if (hit_at >= 0) begin
                    hits_seen++;
                    add_result(K_HIT, hit_at[FRAME_W-1:0], pid[PAGE_W-1:0], '0);
                end else if (free_at >= 0) begin
                    cached_valid[free_at] = 1'b1;
                    cached_dirty[free_at] = 1'b0;
                    cached_page[free_at]  = pid[PAGE_W-1:0];
                    misses_seen++;
                    add_result(K_LOAD, free_at[FRAME_W-1:0], pid[PAGE_W-1:0], '0);
                end else begin
                    // Round-robin eviction, writing back a dirty victim first
                    v = next_victim;
                    if (cached_dirty[v]) begin
                        wbacks_seen++;
                        add_result(K_WB, FRAME_W'(v), cached_page[v], '0);
                    end
                    evicts_seen++;
                    next_victim     = IDX_W'((int'(v) + 1) % FRAMES);
                    cached_page[v]  = pid[PAGE_W-1:0];
                    cached_dirty[v] = 1'b0;
                    cached_valid[v] = 1'b1;
                    misses_seen++;
                    add_result(K_EVLOAD, FRAME_W'(v), pid[PAGE_W-1:0], '0);
                end
            end
        end else if (op == OP_MARK) begin
            if (cached_valid[idx]) begin
                cached_dirty[idx] = 1'b1;
                pg = cached_page[idx];
            end
            add_result(K_MARK, idx, pg, '0);
        end else if (op == OP_FLUSH) begin
            for (int i = 0; i < FRAMES; i++) begin
                if (cached_valid[i] && cached_dirty[i]) begin
                    add_result(K_FWRITE, i[FRAME_W-1:0], cached_page[i], '0);
                    cached_dirty[i] = 1'b0;
                    flushed++;
                end
            end
            wbacks_seen += STAT_W'(flushed);
            add_result(K_FDONE, '0, '0, flushed);
        end else begin
            add_result(K_REJECT, '0, '0, '0);
        end
        // Every result carries the counters after the whole request
        foreach (step_results[k]) begin
            step_results[k].hits       = hits_seen;
            step_results[k].misses     = misses_seen;
            step_results[k].evictions  = evicts_seen;
            step_results[k].writebacks = wbacks_seen;
            step_results[k].last       = (k == step_results.size() - 1);
        end
    endfunction

    // Flag one field of a result
    function automatic void check_field(input string name, input logic [STAT_W-1:0] want,
                                        input logic [STAT_W-1:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, name, want, got);
        end
    endfunction

    // Idle cycles before one transaction on either side
    function automatic int draw_gap();
        return quiet ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    // Random request: mostly fetches of pages from a small pool, so hits and evictions mix
    function automatic t_row random_row();
        t_row row;
        int   pick;
        row     = '0;
        row.idx = FRAME_W'($urandom_range(0, FRAMES - 1));
        row.pid = $urandom();
        pick    = $urandom_range(0, 99);
        if (pick < 60) begin
            row.op = OP_FETCH;
            pick   = $urandom_range(0, 99);
            if (pick < 70)
                row.pid = {1'b0, page_pool[$urandom_range(0, POOL_SIZE - 1)]};
            else if (pick < 85)
                row.pid = $urandom() >> 1;
        end else if (pick < 85) begin
            row.op = OP_MARK;
        end else if (pick < 95) begin
            row.op = OP_FLUSH;
        end else begin
            row.op = OP_SPARE;
        end
        return row;
    endfunction

    // Offer one request and hold it until the block takes it
    task automatic offer(input t_row row);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        offered_rows.push_back(row);
        req_if.valid       <= 1'b1;
        req_if.operation   <= row.op;
        req_if.page_id     <= row.pid;
        req_if.frame_index <= row.idx;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
    endtask

    // Predict on each accepted request, check each accepted result
    always @(posedge i_clk) begin : track
        t_row pin;
        t_res want;
        if (i_rst_n && req_if.valid && req_if.ready) begin
            pin = offered_rows.pop_front();
            advance_cache(req_if.operation, req_if.page_id, req_if.frame_index);
            if (pin.typed) begin
                step_results[0].kind  = pin.kind;
                step_results[0].frame = pin.frame;
                step_results[0].page  = pin.page;
                step_results[0].count = pin.count;
            end
            foreach (step_results[k]) due_results.push_back(step_results[k]);
        end
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (due_results.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: result with nothing pending, kind %0d frame %0d",
                             $realtime, res_if.kind, res_if.frame);
            end else begin
                want = due_results.pop_front();
                check_field("kind",            want.kind,       res_if.kind);
                check_field("frame",           want.frame,      res_if.frame);
                check_field("disk_page",       want.page,       res_if.disk_page);
                check_field("flushed_count",   want.count,      res_if.flushed_count);
                check_field("hit_count",       want.hits,       res_if.hit_count);
                check_field("miss_count",      want.misses,     res_if.miss_count);
                check_field("eviction_count",  want.evictions,  res_if.eviction_count);
                check_field("writeback_count", want.writebacks, res_if.writeback_count);
                check_field("last",            want.last,       res_if.last);
            end
        end
    end

    // Abort when no transaction moves for too long
    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready))
            stalled_cycles <= 0;
        else
            stalled_cycles <= stalled_cycles + 1;
        if (stalled_cycles >= STALL_LIMIT) begin
            $display("page_frame_cache_round_robin_unit_test: done, errors");
            $finish;
        end
    end

    // Result side: random stalls, plus one long hold-off on request
    initial begin : drain
        int gap;
        res_if.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            gap = draw_gap() + hold_off_cycles;
            hold_off_cycles = 0;
            if (gap > 0) begin
                res_if.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            res_if.ready <= 1'b1;
            @(posedge i_clk);
            while (!res_if.valid) @(posedge i_clk);
        end
    end

    // Request side: reset, directed table, random phases, drain
    initial begin : stimulus
        i_rst_n            <= 1'b0;
        req_if.valid       <= 1'b0;
        req_if.operation   <= OP_FETCH;
        req_if.page_id     <= '0;
        req_if.frame_index <= '0;
        for (int i = 0; i < POOL_SIZE; i++)
            page_pool[i] = (i < 8) ? PAGE_W'(i) : PAGE_W'($urandom() >> 1);
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        quiet = 1'b0;
        for (int r = 0; r < DIRECTED_ROWS; r++)
            offer(DIRECTED[r]);

        // Phase 0 runs without idling, phase 2 starts with a long result stall
        for (int ph = 0; ph < PHASES; ph++) begin
            quiet = (ph == 0);
            if (ph == 2)
                hold_off_cycles = LONG_HOLD;
            repeat (RANDOM_PER_PHASE) offer(random_row());
        end

        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0)
            $display("page_frame_cache_round_robin_unit_test: done, clean");
        else
            $display("page_frame_cache_round_robin_unit_test: done, errors");
        $finish;
    end

endmodule
